// ===== sv/fba_pkg.sv =====
// fba_pkg: shared types and constants for the bitmap frame allocator
// operation and status codes, controller states, and the command and status
// bundles between the controller and the datapath; depends on nothing
package fba_pkg;

	// width of a frame number on the request and result ports
	localparam int FRAME_NUM_BITS = 12;

	// operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_ALLOCATED    = 3'd0,
		ST_MAPPED       = 3'd1,
		ST_NO_FRAME     = 3'd2,
		ST_FREED        = 3'd3,
		ST_FREE_IGNORED = 3'd4
	} fba_status_t;

	// controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_QUOT,
		S_SPLIT,
		S_HREAD,
		S_HCHK,
		S_SCAN,
		S_WRITE
	} fba_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic        capture;
		logic        quot;
		logic        split;
		logic        rd_hint;
		logic        scan_start;
		logic        scan_step;
		logic        tgt_hint;
		logic        tgt_scan;
		logic        wr_word;
		logic        wr_set;
		logic        clr_step;
		logic        resp;
		fba_status_t resp_status;
	} fba_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic func;
		logic mapped;
		logic use_hint;
		logic hint_ok;
		logic hint_used;
		logic scan_hit;
		logic scan_miss_last;
		logic clr_last;
	} fba_stat_t;

endpackage

// ===== sv/fba_datapath.sv =====
// fba_datapath: request registers, hint split, bitmap memory, word scan and
// result registers of the bitmap frame allocator
// depends on fba_pkg; driven by fba_ctrl through fba_cmd_t
module fba_datapath import fba_pkg::*; #(
	parameter int NUM_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fba_cmd_t                  cmd,
	output fba_stat_t                 stat,
	input  logic                      func,
	input  logic [FRAME_NUM_BITS-1:0] frame_number,
	input  logic                      use_hint,
	input  logic                      page_mapped,
	input  logic                      kernel_mode,
	input  logic                      writable_request,
	output logic                      done,
	output logic [2:0]                status,
	output logic [FRAME_NUM_BITS-1:0] granted_frame,
	output logic                      user_access,
	output logic                      write_access
);

	localparam int FRAME_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int CW = $clog2(FRAME_WORDS + 1);
	localparam int BW = $clog2(WORD_BITS);
	localparam int SH = FRAME_NUM_BITS + BW;
	localparam int PW = SH + 1 + FRAME_NUM_BITS;
	localparam int RECIP = (1 << SH) / WORD_BITS;
	localparam int IW = AW + BW + 1;
	localparam int LAST_BITS = NUM_FRAMES - (FRAME_WORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_PAD =
		~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
	localparam logic [AW-1:0] LAST_WORD = AW'(FRAME_WORDS - 1);
	localparam logic [FRAME_NUM_BITS-1:0] WB_N = FRAME_NUM_BITS'(WORD_BITS);

	// request registers
	logic                      func_q;
	logic                      use_hint_q;
	logic                      mapped_q;
	logic                      kernel_q;
	logic                      wreq_q;
	logic [FRAME_NUM_BITS-1:0] frame_q;
	logic                      hint_ok_q;

	// hint split into word and bit
	logic [FRAME_NUM_BITS-1:0] hq_q;
	logic [AW-1:0]             hword_q;
	logic [BW-1:0]             hbit_q;

	// scan and clear address, read tag
	logic [CW-1:0]             scan_q;
	logic                      rvld_q;
	logic [AW-1:0]             raddr_q;

	// bitmap memory
	logic [WORD_BITS-1:0]      mem [FRAME_WORDS];
	logic [WORD_BITS-1:0]      rdata_q;

	// target word for the update
	logic [AW-1:0]             tw_q;
	logic [BW-1:0]             tb_q;
	logic [WORD_BITS-1:0]      td_q;

	// result registers
	logic                      done_q;
	logic [2:0]                status_q;
	logic [FRAME_NUM_BITS-1:0] granted_q;
	logic                      user_q;
	logic                      wracc_q;

	logic [PW-1:0]             prod;
	logic [FRAME_NUM_BITS-1:0] rem;
	logic [FRAME_NUM_BITS-1:0] rem_adj;
	logic [FRAME_NUM_BITS-1:0] hword_est;
	logic                      corr;
	logic                      scan_more;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [WORD_BITS-1:0]      wr_data;
	logic [WORD_BITS-1:0]      word_eff;
	logic                      hit;
	logic [BW-1:0]             ffz_bit;
	logic [IW-1:0]             frame_full;

	// quotient estimate by reciprocal, then one correction step
	always_comb begin
		prod = PW'(frame_q) * PW'(RECIP);
		rem = frame_q - FRAME_NUM_BITS'(hq_q * WB_N);
		corr = (rem >= WB_N);
		hword_est = hq_q + FRAME_NUM_BITS'(corr);
		rem_adj = corr ? (rem - WB_N) : rem;
	end

	// memory port selection
	always_comb begin
		scan_more = (scan_q < CW'(FRAME_WORDS));
		rd_en = cmd.rd_hint | (cmd.scan_step & scan_more);
		rd_addr = cmd.rd_hint ? hword_q : scan_q[AW-1:0];
		wr_en = cmd.wr_word | cmd.clr_step;
		wr_addr = cmd.clr_step ? scan_q[AW-1:0] : tw_q;
		wr_data = td_q;
		wr_data[tb_q] = cmd.wr_set;
		if (cmd.clr_step) begin
			wr_data = '0;
		end
	end

	// lowest zero bit of the scanned word, frames past the end count as used
	always_comb begin
		word_eff = rdata_q | ((raddr_q == LAST_WORD) ? LAST_PAD : '0);
		hit = 1'b0;
		ffz_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word_eff[i]) begin
				hit = 1'b1;
				ffz_bit = BW'(i);
			end
		end
	end

	assign frame_full = IW'(tw_q) * IW'(WORD_BITS) + IW'(tb_q);

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// scan and clear counter, read tag and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			rvld_q <= 1'b0;
			raddr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.resp;
			if (cmd.clr_step) begin
				scan_q <= scan_q + CW'(1);
			end else if (cmd.scan_start) begin
				scan_q <= '0;
				rvld_q <= 1'b0;
			end else if (cmd.scan_step) begin
				rvld_q <= scan_more;
				raddr_q <= scan_q[AW-1:0];
				if (scan_more) begin
					scan_q <= scan_q + CW'(1);
				end
			end
		end
	end

	// request, split, target and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			use_hint_q <= use_hint;
			mapped_q <= page_mapped;
			kernel_q <= kernel_mode;
			wreq_q <= writable_request;
			frame_q <= frame_number;
			hint_ok_q <= (32'(frame_number) < 32'(NUM_FRAMES));
		end
		if (cmd.quot) begin
			hq_q <= FRAME_NUM_BITS'(prod >> SH);
		end
		if (cmd.split) begin
			hword_q <= AW'(hword_est);
			hbit_q <= BW'(rem_adj);
		end
		if (cmd.tgt_hint) begin
			tw_q <= hword_q;
			tb_q <= hbit_q;
			td_q <= rdata_q;
		end else if (cmd.tgt_scan) begin
			tw_q <= raddr_q;
			tb_q <= ffz_bit;
			td_q <= rdata_q;
		end
		if (cmd.resp) begin
			status_q <= cmd.resp_status;
			if (cmd.resp_status == ST_ALLOCATED) begin
				granted_q <= FRAME_NUM_BITS'(frame_full);
				user_q <= ~kernel_q;
				wracc_q <= wreq_q;
			end else begin
				granted_q <= '0;
				user_q <= 1'b0;
				wracc_q <= 1'b0;
			end
		end
	end

	// status toward the controller
	always_comb begin
		stat.func = func_q;
		stat.mapped = mapped_q;
		stat.use_hint = use_hint_q;
		stat.hint_ok = hint_ok_q;
		stat.hint_used = rdata_q[hbit_q];
		stat.scan_hit = rvld_q & hit;
		stat.scan_miss_last = rvld_q & ~hit & (raddr_q == LAST_WORD);
		stat.clr_last = (scan_q == CW'(FRAME_WORDS - 1));
	end

	assign done = done_q;
	assign status = status_q;
	assign granted_frame = granted_q;
	assign user_access = user_q;
	assign write_access = wracc_q;

endmodule

// ===== sv/fba_ctrl.sv =====
// fba_ctrl: controller state machine of the bitmap frame allocator
// sequences clear, hint split, hint check, word scan and update
// depends on fba_pkg; drives fba_datapath through fba_cmd_t
module fba_ctrl import fba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  fba_stat_t stat,
	output fba_cmd_t  cmd,
	output logic      busy
);

	fba_state_t state_q;
	fba_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.resp_status = ST_ALLOCATED;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = S_QUOT;
				end
			end
			S_QUOT: begin
				cmd.quot = 1'b1;
				state_d = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.split = 1'b1;
				if (stat.func == FUNC_ALLOC) begin
					if (stat.mapped) begin
						cmd.resp = 1'b1;
						cmd.resp_status = ST_MAPPED;
						state_d = S_IDLE;
					end else if (stat.use_hint && stat.hint_ok) begin
						state_d = S_HREAD;
					end else begin
						cmd.scan_start = 1'b1;
						state_d = S_SCAN;
					end
				end else begin
					if (stat.mapped && stat.hint_ok) begin
						state_d = S_HREAD;
					end else begin
						cmd.resp = 1'b1;
						cmd.resp_status = ST_FREE_IGNORED;
						state_d = S_IDLE;
					end
				end
			end
			S_HREAD: begin
				cmd.rd_hint = 1'b1;
				state_d = S_HCHK;
			end
			S_HCHK: begin
				cmd.tgt_hint = 1'b1;
				if (stat.func == FUNC_FREE || !stat.hint_used) begin
					state_d = S_WRITE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_hit) begin
					cmd.tgt_scan = 1'b1;
					state_d = S_WRITE;
				end else if (stat.scan_miss_last) begin
					cmd.resp = 1'b1;
					cmd.resp_status = ST_NO_FRAME;
					state_d = S_IDLE;
				end
			end
			S_WRITE: begin
				cmd.wr_word = 1'b1;
				cmd.wr_set = (stat.func == FUNC_ALLOC);
				cmd.resp = 1'b1;
				cmd.resp_status = (stat.func == FUNC_ALLOC) ? ST_ALLOCATED : ST_FREED;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: top level of the first-fit physical frame allocator
// joins fba_ctrl and fba_datapath; depends on fba_pkg
//
// A request is taken when start is high and busy is low; its one result shows
// on status, granted_frame, user_access and write_access for one cycle with
// done high, and must be captured then since there is no hold-off. After
// reset the block sweeps the bitmap memory to zero, one word per cycle, and
// keeps busy high until the last word is cleared. A mapped-page allocate or
// an ignored free is answered from the split state; a free or a hinted
// allocate that lands reads the hint word, checks it and then writes it
// back; an allocate that scans reads bitmap words up to the first word with
// a free frame, after reading and checking the hint word when a used hint
// was given. The scan reads one word per cycle from the bitmap memory,
// which has one read port and one write port; a new request is accepted in
// the cycle done is high.
module bitmap_frame_allocator import fba_pkg::*; #(
	parameter int NUM_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [FRAME_NUM_BITS-1:0] frame_number,
	input  logic                      use_hint,
	input  logic                      page_mapped,
	input  logic                      kernel_mode,
	input  logic                      writable_request,
	output logic                      done,
	output logic [2:0]                status,
	output logic [FRAME_NUM_BITS-1:0] granted_frame,
	output logic                      user_access,
	output logic                      write_access
);

	fba_cmd_t  cmd;
	fba_stat_t stat;

	// controller
	fba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath with bitmap memory
	fba_datapath #(
		.NUM_FRAMES (NUM_FRAMES),
		.WORD_BITS  (WORD_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.func             (func),
		.frame_number     (frame_number),
		.use_hint         (use_hint),
		.page_mapped      (page_mapped),
		.kernel_mode      (kernel_mode),
		.writable_request (writable_request),
		.done             (done),
		.status           (status),
		.granted_frame    (granted_frame),
		.user_access      (user_access),
		.write_access     (write_access)
	);

endmodule

// ===== sv/fba_checker.sv =====
// fba_checker: port-level assertions for the bitmap frame allocator
// bound to bitmap_frame_allocator; depends on fba_pkg
module fba_checker import fba_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [2:0]                status,
	input logic [FRAME_NUM_BITS-1:0] granted_frame,
	input logic                      user_access,
	input logic                      write_access
);

	// an accepted item holds the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// a result shows only once the item is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	// results are single-cycle strobes
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// status codes stay in the defined set
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_ALLOCATED || status == ST_MAPPED ||
			status == ST_NO_FRAME || status == ST_FREED ||
			status == ST_FREE_IGNORED))
		else $error("undefined status code");

	// only a granted frame carries frame and access bits
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_ALLOCATED) |->
			(granted_frame == '0 && !user_access && !write_access))
		else $error("nonzero fields on a result without a grant");

endmodule

bind bitmap_frame_allocator fba_checker u_fba_checker (.*);

// ===== tb/sv/frame_map_monitor.sv =====
`timescale 1ns / 1ps
// frame_map_monitor: watches the request and result ports of the frame allocator,
// keeps its own copy of the frame bitmap, predicts each result and compares it
// depends on fba_pkg for the frame number width and the status codes
module frame_map_monitor import fba_pkg::*; #(
	parameter int NUM_FRAMES = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      func,
	input  logic [FRAME_NUM_BITS-1:0] frame_number,
	input  logic                      use_hint,
	input  logic                      page_mapped,
	input  logic                      kernel_mode,
	input  logic                      writable_request,
	input  logic                      done,
	input  logic [2:0]                status,
	input  logic [FRAME_NUM_BITS-1:0] granted_frame,
	input  logic                      user_access,
	input  logic                      write_access,
	output int                        errors,
	output int                        pending
);

	// one predicted result
	typedef struct packed {
		fba_status_t               st;
		logic [FRAME_NUM_BITS-1:0] frame;
		logic                      user;
		logic                      wr;
	} grant_t;

	// one bit per frame, set while the frame is in use
	logic [NUM_FRAMES-1:0] used_map;
	grant_t                grant_q[$];

	// apply one request to the bitmap and work out its result
	function automatic grant_t serve_request(input logic fn, input logic [FRAME_NUM_BITS-1:0] fr,
			input logic hint, input logic mapped, input logic kern, input logic wr);
		grant_t g;
		int     pick;
		int     f;
		g.st    = ST_ALLOCATED;
		g.frame = '0;
		g.user  = 1'b0;
		g.wr    = 1'b0;
		pick    = -1;
		if (fn == FUNC_ALLOC) begin
			if (mapped) begin
				g.st = ST_MAPPED;
			end else begin
				// hinted frame if free, else first fit from frame zero
				if (hint && int'(fr) < NUM_FRAMES && !used_map[fr]) begin
					pick = int'(fr);
				end else begin
					for (f = 0; f < NUM_FRAMES && pick < 0; f++)
						if (!used_map[f])
							pick = f;
				end
				if (pick >= 0) begin
					used_map[pick] = 1'b1;
					g.frame        = FRAME_NUM_BITS'(pick);
					g.user         = !kern;
					g.wr           = wr;
				end else begin
					g.st = ST_NO_FRAME;
				end
			end
		end else if (mapped && int'(fr) < NUM_FRAMES) begin
			// freeing a frame that is already free still reports freed
			used_map[fr] = 1'b0;
			g.st         = ST_FREED;
		end else begin
			g.st = ST_FREE_IGNORED;
		end
		return g;
	endfunction

	task automatic check_field(input string name, input logic [FRAME_NUM_BITS-1:0] want,
			input logic [FRAME_NUM_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// results are compared before the request taken at the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			used_map = '0;
			grant_q.delete();
			errors   = 0;
			pending  = 0;
		end else begin
			if (done) begin
				if (grant_q.size() == 0) begin
					$error("result with no item outstanding: status %0d, frame %0d",
						status, granted_frame);
					errors++;
				end else begin
					want = grant_q.pop_front();
					check_field("status", FRAME_NUM_BITS'(want.st),
						FRAME_NUM_BITS'(status));
					check_field("granted_frame", want.frame, granted_frame);
					check_field("user_access", FRAME_NUM_BITS'(want.user),
						FRAME_NUM_BITS'(user_access));
					check_field("write_access", FRAME_NUM_BITS'(want.wr),
						FRAME_NUM_BITS'(write_access));
				end
			end
			if (start && !busy)
				grant_q.push_back(serve_request(func, frame_number, use_hint, page_mapped,
					kernel_mode, writable_request));
			pending = grant_q.size();
		end
	end

endmodule

// ===== tb/sv/bitmap_frame_allocator_tb.sv =====
`timescale 1ns / 1ps
// bitmap_frame_allocator_tb: stimulus and verdict for the frame allocator
// drives directed and random items; frame_map_monitor does the checking
// depends on fba_pkg, bitmap_frame_allocator and frame_map_monitor
module bitmap_frame_allocator_tb import fba_pkg::*;;

	localparam int NUM_FRAMES   = 4096;
	localparam int WORD_BITS    = 32;
	localparam int RANDOM_ITEMS = 860;
	localparam int DRAIN_CYCLES = 150;

	logic                      clk              = 1'b0;
	logic                      arst_n           = 1'b0;
	logic                      start            = 1'b0;
	logic                      func             = FUNC_ALLOC;
	logic [FRAME_NUM_BITS-1:0] frame_number     = '0;
	logic                      use_hint         = 1'b0;
	logic                      page_mapped      = 1'b0;
	logic                      kernel_mode      = 1'b0;
	logic                      writable_request = 1'b0;
	logic                      busy;
	logic                      done;
	logic [2:0]                status;
	logic [FRAME_NUM_BITS-1:0] granted_frame;
	logic                      user_access;
	logic                      write_access;
	int                        errors;
	int                        pending;
	bit                        calm = 1'b0;

	always #5 clk = ~clk;

	bitmap_frame_allocator #(
		.NUM_FRAMES(NUM_FRAMES),
		.WORD_BITS (WORD_BITS)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.frame_number    (frame_number),
		.use_hint        (use_hint),
		.page_mapped     (page_mapped),
		.kernel_mode     (kernel_mode),
		.writable_request(writable_request),
		.done            (done),
		.status          (status),
		.granted_frame   (granted_frame),
		.user_access     (user_access),
		.write_access    (write_access)
	);

	frame_map_monitor #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.frame_number    (frame_number),
		.use_hint        (use_hint),
		.page_mapped     (page_mapped),
		.kernel_mode     (kernel_mode),
		.writable_request(writable_request),
		.done            (done),
		.status          (status),
		.granted_frame   (granted_frame),
		.user_access     (user_access),
		.write_access    (write_access),
		.errors          (errors),
		.pending         (pending)
	);

	// hard stop well beyond the slowest correct run
	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// drive one item from a falling edge and hold it until accepted; start stays
	// high on return, so the caller either sends again or calls wait_drained
	task automatic send_req(input logic fn, input logic [FRAME_NUM_BITS-1:0] fr,
			input logic hint, input logic mapped, input logic kern, input logic wr);
		int gap;
		if (!calm && $urandom_range(99) < 29) begin
			gap = $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start            <= 1'b1;
		func             <= fn;
		frame_number     <= fr;
		use_hint         <= hint;
		page_mapped      <= mapped;
		kernel_mode      <= kern;
		writable_request <= wr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop sending until every outstanding result has come back
	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// mostly well-formed allocates and frees, some noise
	task automatic send_random();
		int                        kind;
		int                        spread;
		logic [FRAME_NUM_BITS-1:0] fr;
		kind   = $urandom_range(99);
		spread = $urandom_range(3);
		if (spread == 0)
			fr = FRAME_NUM_BITS'($urandom_range(0, NUM_FRAMES - 1));
		else if (spread == 1)
			fr = FRAME_NUM_BITS'($urandom_range(0, 767));
		else
			fr = FRAME_NUM_BITS'($urandom_range(0, 255));
		if (kind < 45)
			send_req(FUNC_ALLOC, fr, 1'($urandom_range(1)), $urandom_range(9) == 0,
				1'($urandom_range(1)), 1'($urandom_range(1)));
		else if (kind < 85)
			send_req(FUNC_FREE, fr, 1'($urandom_range(1)), $urandom_range(9) != 0,
				1'($urandom_range(1)), 1'($urandom_range(1)));
		else
			send_req(1'($urandom_range(1)), FRAME_NUM_BITS'($urandom),
				1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
	endtask

	initial begin
		int i;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: first fit, hints good and bad, mapped pages, frees
		send_req(FUNC_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, 1'b1);
		send_req(FUNC_ALLOC, 12'd4095, 1'b0, 1'b0, 1'b1, 1'b0);
		send_req(FUNC_ALLOC, 12'd4095, 1'b1, 1'b0, 1'b1, 1'b1);
		// hint on a used frame falls back to the scan
		send_req(FUNC_ALLOC, 12'd4095, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(FUNC_ALLOC, 12'd0, 1'b1, 1'b0, 1'b1, 1'b0);
		send_req(FUNC_ALLOC, 12'd100, 1'b1, 1'b1, 1'b0, 1'b1);
		// free on an unmapped page is ignored
		send_req(FUNC_FREE, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0);
		send_req(FUNC_FREE, 12'd4095, 1'b0, 1'b1, 1'b1, 1'b1);
		// freeing an already free frame
		send_req(FUNC_FREE, 12'd4095, 1'b1, 1'b1, 1'b0, 1'b0);
		send_req(FUNC_FREE, 12'd1, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(FUNC_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		send_req(FUNC_ALLOC, 12'd1000, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(FUNC_FREE, 12'd0, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(FUNC_ALLOC, 12'd0, 1'b1, 1'b0, 1'b1, 1'b1);
		send_req(FUNC_FREE, 12'd2, 1'b0, 1'b1, 1'b1, 1'b1);
		send_req(FUNC_FREE, 12'd0, 1'b1, 1'b0, 1'b1, 1'b0);
		send_req(FUNC_ALLOC, 12'd2, 1'b1, 1'b1, 1'b1, 1'b1);
		wait_drained();

		// random traffic with one stretch of back-to-back items
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 300 && i < 500);
			send_random();
		end
		calm = 1'b0;
		wait_drained();

		// mapped allocate, frees around the last frame and hinted allocates
		send_req(FUNC_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, 1'b1);
		send_req(FUNC_ALLOC, 12'd100, 1'b1, 1'b0, 1'b1, 1'b0);
		send_req(FUNC_ALLOC, 12'd100, 1'b1, 1'b1, 1'b1, 1'b0);
		send_req(FUNC_FREE, 12'd4095, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(FUNC_ALLOC, 12'd0, 1'b0, 1'b0, 1'b0, 1'b1);
		send_req(FUNC_FREE, 12'd4095, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(FUNC_FREE, 12'd2000, 1'b0, 1'b0, 1'b0, 1'b0);
		send_req(FUNC_FREE, 12'd2000, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(FUNC_FREE, 12'd37, 1'b0, 1'b1, 1'b0, 1'b0);
		send_req(FUNC_ALLOC, 12'd4095, 1'b0, 1'b0, 1'b1, 1'b1);
		send_req(FUNC_ALLOC, 12'd4095, 1'b1, 1'b0, 1'b0, 1'b1);
		send_req(FUNC_ALLOC, 12'd3000, 1'b1, 1'b0, 1'b0, 1'b0);
		send_req(FUNC_ALLOC, 12'd0, 1'b0, 1'b0, 1'b1, 1'b1);

		// let every result come back, then a little longer for strays
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/fba_pkg.sv
sv/fba_datapath.sv
sv/fba_ctrl.sv
sv/bitmap_frame_allocator.sv
sv/fba_checker.sv
tb/sv/frame_map_monitor.sv
tb/sv/bitmap_frame_allocator_tb.sv
